// ===== design/oef3_pkg.sv =====
package oef3_pkg;

   // Field widths fixed by the interface
   localparam int CFG_WIDTH = 24;
   localparam int DT_WIDTH = 17;
   localparam int CSR_INDEX_WIDTH = 2;

   // Parameter defaults
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_CUTOFF = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CUTOFF_SLOPE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DELTA_CUTOFF = 2'd2;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] MIN_CUTOFF_RST = 24'd58982;
   localparam logic [CFG_WIDTH-1:0] CUTOFF_SLOPE_RST = 24'd459;
   localparam logic [CFG_WIDTH-1:0] DELTA_CUTOFF_RST = 24'd65536;

   // 2*pi in Q16.16, always scaled by 16 bits
   localparam int TWO_PI_WIDTH = 19;
   localparam int TWO_PI_SHIFT = 16;
   localparam logic [TWO_PI_WIDTH-1:0] TWO_PI_Q16 = 19'd411775;

endpackage

// ===== design/oef3_div.sv =====
module oef3_div #(
   parameter int DN = 49,
   parameter int DD = 37,
   parameter int CNW = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [CNW-1:0] count,
   input  logic [DN-1:0]  num,
   input  logic [DD-1:0]  rem_init,
   input  logic [DD-1:0]  den,
   output logic           busy,
   output logic [DN-1:0]  quot
);

   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [DD-1:0]  rem_ff, rem_in;
   logic [DN-1:0]  q_ff, q_in;
   logic [DD-1:0]  den_ff, den_in;
   logic [DD+1:0]  trial;

   // Trial subtract of one restoring step
   assign trial = {1'b0, rem_ff, q_ff[DN-1]} - {2'b00, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = count;
         rem_in = rem_init;
         q_in = num;
         den_in = den;
      end else if (busy_ff) begin
         // Shift one dividend bit in, one quotient bit out
         if (!trial[DD+1]) begin
            rem_in = trial[DD-1:0];
         end else begin
            rem_in = {rem_ff[DD-2:0], q_ff[DN-1]};
         end
         q_in = {q_ff[DN-2:0], ~trial[DD+1]};
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff <= q_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

// ===== design/one_euro_filter_3d_core.sv =====
// A first or restart transaction passes its sample straight through; any other
// runs the rate and smoothing steps for each component in turn. One transaction
// at a time: the shared divider (one bit per cycle) and the shared multiplier
// are reused across the steps.
// Reset (synchronous): registers to defaults, filter state cleared, next
// transaction treated as first.
module one_euro_filter_3d_core #(
   parameter int VALUE_WIDTH = oef3_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = oef3_pkg::FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [VALUE_WIDTH-1:0]          req_sample_x,
   input  logic signed [VALUE_WIDTH-1:0]          req_sample_y,
   input  logic signed [VALUE_WIDTH-1:0]          req_sample_z,
   input  logic [oef3_pkg::DT_WIDTH-1:0]          req_time_step,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]          rsp_smooth_x,
   output logic signed [VALUE_WIDTH-1:0]          rsp_smooth_y,
   output logic signed [VALUE_WIDTH-1:0]          rsp_smooth_z,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [oef3_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [oef3_pkg::CFG_WIDTH-1:0]         csr_data
);
   import oef3_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int FB = FRACTION_BITS;
   localparam int CW = (VW > CFG_WIDTH) ? VW : CFG_WIDTH;
   localparam int PW = CW + DT_WIDTH - FB;
   localparam int WW = PW + TWO_PI_WIDTH - TWO_PI_SHIFT;
   localparam int MA = (PW > CW) ? PW : CW;
   localparam int MB = (FB + 1 > CFG_WIDTH) ? FB + 1 : CFG_WIDTH;
   localparam int PRW = MA + MB;
   localparam int AW = FB + 1;
   localparam int ACCW = VW + FB + 1;
   localparam int DN = VW + 1 + FB;
   localparam int DD = WW + 1;
   localparam int CNW = $clog2(DN + 1);
   localparam int FSW = PRW - FB + 1;

   localparam logic [AW-1:0] ONE_A = {1'b1, {FB{1'b0}}};
   localparam logic [ACCW-1:0] HALF = {{(VW + 1){1'b0}}, 1'b1, {(FB - 1){1'b0}}};
   localparam logic [DN-1:0] Q_MAXP = {{(FB + 2){1'b0}}, {(VW - 1){1'b1}}};

   // Sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DC_MUL = 5'd1;
   localparam logic [4:0] S_DC_W = 5'd2;
   localparam logic [4:0] S_DC_DIV = 5'd3;
   localparam logic [4:0] S_DC_WAIT = 5'd4;
   localparam logic [4:0] S_RATE_DIV = 5'd5;
   localparam logic [4:0] S_RATE_WAIT = 5'd6;
   localparam logic [4:0] S_EST_M1 = 5'd7;
   localparam logic [4:0] S_EST_M2 = 5'd8;
   localparam logic [4:0] S_EST_SUM = 5'd9;
   localparam logic [4:0] S_FC_M = 5'd10;
   localparam logic [4:0] S_FC_SUM = 5'd11;
   localparam logic [4:0] S_FC_MUL = 5'd12;
   localparam logic [4:0] S_FC_W = 5'd13;
   localparam logic [4:0] S_FC_DIV = 5'd14;
   localparam logic [4:0] S_FC_WAIT = 5'd15;
   localparam logic [4:0] S_Y_M1 = 5'd16;
   localparam logic [4:0] S_Y_M2 = 5'd17;
   localparam logic [4:0] S_Y_SUM = 5'd18;
   localparam logic [4:0] S_DONE = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [1:0] comp_ff, comp_in;
   logic [CFG_WIDTH-1:0] min_cutoff_ff, min_cutoff_in;
   logic [CFG_WIDTH-1:0] cutoff_slope_ff, cutoff_slope_in;
   logic [CFG_WIDTH-1:0] delta_cutoff_ff, delta_cutoff_in;
   logic first_pending_ff, first_pending_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] x_ff [3];
   logic [VW-1:0] x_in [3];
   logic [VW-1:0] last_s_ff [3];
   logic [VW-1:0] last_s_in [3];
   logic [VW-1:0] last_r_ff [3];
   logic [VW-1:0] last_r_in [3];
   logic [VW-1:0] y_ff [3];
   logic [VW-1:0] y_in [3];
   logic [VW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [DT_WIDTH-1:0] dt_ff, dt_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [AW-1:0] alpha_d_ff, alpha_d_in, alpha_ff, alpha_in;
   logic [VW-1:0] rate_ff, rate_in, est_ff, est_in, fc_ff, fc_in;

   logic [MA-1:0] mul_a;
   logic [MB-1:0] mul_b;
   logic div_start, div_busy;
   logic [CNW-1:0] div_count;
   logic [DN-1:0] div_num, div_quot;
   logic [DD-1:0] div_rem, div_den;

   logic [WW-1:0] w_val;
   logic [PW-1:0] p_val;
   logic [VW:0] diff, mag;
   logic [ACCW-1:0] blend_sum;
   logic [VW-1:0] blend_r, blend_out, est_mag;
   logic [FSW-1:0] fc_sum;
   logic accept;

   oef3_div #(.DN(DN), .DD(DD), .CNW(CNW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (div_count),
      .num      (div_num),
      .rem_init (div_rem),
      .den      (div_den),
      .busy     (div_busy),
      .quot     (div_quot)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Shared datapath terms
   assign w_val = prod_ff[TWO_PI_SHIFT +: WW];
   assign p_val = prod_ff[FB +: PW];
   assign diff = {x_ff[comp_ff][VW-1], x_ff[comp_ff]}
               - {last_s_ff[comp_ff][VW-1], last_s_ff[comp_ff]};
   assign mag = diff[VW] ? -diff : diff;
   assign blend_sum = acc_ff + prod_ff[ACCW-1:0] + HALF;
   assign blend_r = blend_sum[FB +: VW];
   assign blend_out = {~blend_r[VW-1], blend_r[VW-2:0]};
   assign est_mag = est_ff[VW-1] ? -est_ff : est_ff;
   assign fc_sum = {1'b0, prod_ff[PRW-1:FB]} + FSW'(min_cutoff_ff);

   always_comb begin
      state_in = state_ff;
      comp_in = comp_ff;
      min_cutoff_in = min_cutoff_ff;
      cutoff_slope_in = cutoff_slope_ff;
      delta_cutoff_in = delta_cutoff_ff;
      first_pending_in = first_pending_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in = x_ff;
      last_s_in = last_s_ff;
      last_r_in = last_r_ff;
      y_in = y_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_z_in = rsp_z_ff;
      dt_in = dt_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      alpha_d_in = alpha_d_ff;
      alpha_in = alpha_ff;
      rate_in = rate_ff;
      est_in = est_ff;
      fc_in = fc_ff;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_count = CNW'(FB);
      div_num = '0;
      div_rem = '0;
      div_den = '0;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            REG_MIN_CUTOFF: min_cutoff_in = csr_data;
            REG_CUTOFF_SLOPE: cutoff_slope_in = csr_data;
            REG_DELTA_CUTOFF: delta_cutoff_in = csr_data;
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in[0] = req_sample_x;
               x_in[1] = req_sample_y;
               x_in[2] = req_sample_z;
               dt_in = (req_time_step == '0) ? DT_WIDTH'(1) : req_time_step;
               comp_in = 2'd0;
               first_pending_in = 1'b0;
               if (first_pending_ff || req_restart) begin
                  // Pass the sample through and restart both smoothers
                  for (int i = 0; i < 3; i++) begin
                     last_r_in[i] = '0;
                  end
                  last_s_in[0] = req_sample_x;
                  last_s_in[1] = req_sample_y;
                  last_s_in[2] = req_sample_z;
                  y_in[0] = req_sample_x;
                  y_in[1] = req_sample_y;
                  y_in[2] = req_sample_z;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DC_MUL;
               end
            end
         end
         S_DC_MUL: begin
            mul_a = MA'(delta_cutoff_ff);
            mul_b = MB'(dt_ff);
            prod_in = mul_a * mul_b;
            state_in = S_DC_W;
         end
         S_DC_W: begin
            mul_a = MA'(p_val);
            mul_b = MB'(TWO_PI_Q16);
            prod_in = mul_a * mul_b;
            state_in = S_DC_DIV;
         end
         S_DC_DIV: begin
            div_start = 1'b1;
            div_rem = DD'(w_val);
            div_den = DD'(w_val) + DD'(ONE_A);
            state_in = S_DC_WAIT;
         end
         S_DC_WAIT: begin
            if (!div_busy) begin
               alpha_d_in = div_quot[AW-1:0];
               state_in = S_RATE_DIV;
            end
         end
         S_RATE_DIV: begin
            div_start = 1'b1;
            div_count = CNW'(DN);
            div_num = {mag, {FB{1'b0}}};
            div_den = DD'(dt_ff);
            state_in = S_RATE_WAIT;
         end
         S_RATE_WAIT: begin
            // Saturate the raw rate to the signed range
            if (!div_busy) begin
               if (diff[VW]) begin
                  if (div_quot > Q_MAXP + DN'(1)) begin
                     rate_in = {1'b1, {(VW - 1){1'b0}}};
                  end else begin
                     rate_in = -div_quot[VW-1:0];
                  end
               end else begin
                  if (div_quot > Q_MAXP) begin
                     rate_in = {1'b0, {(VW - 1){1'b1}}};
                  end else begin
                     rate_in = div_quot[VW-1:0];
                  end
               end
               state_in = S_EST_M1;
            end
         end
         S_EST_M1: begin
            mul_a = MA'({~rate_ff[VW-1], rate_ff[VW-2:0]});
            mul_b = MB'(alpha_d_ff);
            prod_in = mul_a * mul_b;
            state_in = S_EST_M2;
         end
         S_EST_M2: begin
            acc_in = prod_ff[ACCW-1:0];
            mul_a = MA'({~last_r_ff[comp_ff][VW-1], last_r_ff[comp_ff][VW-2:0]});
            mul_b = MB'(ONE_A - alpha_d_ff);
            prod_in = mul_a * mul_b;
            state_in = S_EST_SUM;
         end
         S_EST_SUM: begin
            est_in = blend_out;
            state_in = S_FC_M;
         end
         S_FC_M: begin
            mul_a = MA'(est_mag);
            mul_b = MB'(cutoff_slope_ff);
            prod_in = mul_a * mul_b;
            state_in = S_FC_SUM;
         end
         S_FC_SUM: begin
            // Saturate the cutoff to the unsigned range
            if (fc_sum[FSW-1:VW] != '0) begin
               fc_in = '1;
            end else begin
               fc_in = fc_sum[VW-1:0];
            end
            state_in = S_FC_MUL;
         end
         S_FC_MUL: begin
            mul_a = MA'(fc_ff);
            mul_b = MB'(dt_ff);
            prod_in = mul_a * mul_b;
            state_in = S_FC_W;
         end
         S_FC_W: begin
            mul_a = MA'(p_val);
            mul_b = MB'(TWO_PI_Q16);
            prod_in = mul_a * mul_b;
            state_in = S_FC_DIV;
         end
         S_FC_DIV: begin
            div_start = 1'b1;
            div_rem = DD'(w_val);
            div_den = DD'(w_val) + DD'(ONE_A);
            state_in = S_FC_WAIT;
         end
         S_FC_WAIT: begin
            if (!div_busy) begin
               alpha_in = div_quot[AW-1:0];
               state_in = S_Y_M1;
            end
         end
         S_Y_M1: begin
            mul_a = MA'({~x_ff[comp_ff][VW-1], x_ff[comp_ff][VW-2:0]});
            mul_b = MB'(alpha_ff);
            prod_in = mul_a * mul_b;
            state_in = S_Y_M2;
         end
         S_Y_M2: begin
            acc_in = prod_ff[ACCW-1:0];
            mul_a = MA'({~last_s_ff[comp_ff][VW-1], last_s_ff[comp_ff][VW-2:0]});
            mul_b = MB'(ONE_A - alpha_ff);
            prod_in = mul_a * mul_b;
            state_in = S_Y_SUM;
         end
         S_Y_SUM: begin
            // Commit this component, advance to the next
            last_s_in[comp_ff] = blend_out;
            last_r_in[comp_ff] = est_ff;
            y_in[comp_ff] = blend_out;
            if (comp_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               comp_in = comp_ff + 2'd1;
               state_in = S_RATE_DIV;
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_x_in = y_ff[0];
               rsp_y_in = y_ff[1];
               rsp_z_in = y_ff[2];
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         comp_ff <= 2'd0;
         min_cutoff_ff <= MIN_CUTOFF_RST;
         cutoff_slope_ff <= CUTOFF_SLOPE_RST;
         delta_cutoff_ff <= DELTA_CUTOFF_RST;
         first_pending_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            last_s_ff[i] <= '0;
            last_r_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         comp_ff <= comp_in;
         min_cutoff_ff <= min_cutoff_in;
         cutoff_slope_ff <= cutoff_slope_in;
         delta_cutoff_ff <= delta_cutoff_in;
         first_pending_ff <= first_pending_in;
         rsp_valid_ff <= rsp_valid_in;
         last_s_ff <= last_s_in;
         last_r_ff <= last_r_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
      dt_ff <= dt_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      alpha_d_ff <= alpha_d_in;
      alpha_ff <= alpha_in;
      rate_ff <= rate_in;
      est_ff <= est_in;
      fc_ff <= fc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_smooth_x = rsp_x_ff;
   assign rsp_smooth_y = rsp_y_ff;
   assign rsp_smooth_z = rsp_z_ff;

endmodule

// ===== sim/one_euro_filter_3d_core_tb.sv =====
module one_euro_filter_3d_core_tb;
   import oef3_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int FB = FRACTION_BITS_DEF;
   localparam int RANDOM_PER_PHASE = 286;
   localparam int DRAIN_LIMIT = 200000;

   typedef struct {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
      logic [DT_WIDTH-1:0]  dt;
      logic                 restart;
   } sample_t;

   typedef struct {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
   } smooth_t;

   // Filter predictor plus the queue of smoothed outputs still owed by the block
   class smoothing_tracker;
      logic [CFG_WIDTH-1:0] min_cutoff;
      logic [CFG_WIDTH-1:0] cutoff_slope;
      logic [CFG_WIDTH-1:0] delta_cutoff;
      longint last_val[3];
      longint last_rate[3];
      bit first_pending;
      smooth_t expected_smooth[$];
      int mismatches;

      function new();
         min_cutoff = MIN_CUTOFF_RST;
         cutoff_slope = CUTOFF_SLOPE_RST;
         delta_cutoff = DELTA_CUTOFF_RST;
         for (int i = 0; i < 3; i++) begin
            last_val[i] = 0;
            last_rate[i] = 0;
         end
         first_pending = 1;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
         case (idx)
            REG_MIN_CUTOFF: min_cutoff = val;
            REG_CUTOFF_SLOPE: cutoff_slope = val;
            REG_DELTA_CUTOFF: delta_cutoff = val;
            default: ;
         endcase
      endfunction

      function logic [63:0] alpha_for(logic [63:0] fc, logic [63:0] dt);
         logic [63:0] p;
         logic [63:0] w;
         p = (fc * dt) >> FB;
         w = (p * 64'(TWO_PI_Q16)) >> TWO_PI_SHIFT;
         return (w << FB) / (w + (64'd1 << FB));
      endfunction

      // Blend in offset-binary so the rounding matches ties upward
      function longint mix(logic [63:0] alpha, longint a, longint b);
         logic [63:0] ua;
         logic [63:0] ub;
         logic [63:0] r;
         ua = a + (64'sd1 <<< (VW - 1));
         ub = b + (64'sd1 <<< (VW - 1));
         r = (alpha * ua + ((64'd1 << FB) - alpha) * ub + (64'd1 << (FB - 1))) >> FB;
         return longint'(r) - (64'sd1 <<< (VW - 1));
      endfunction

      function longint rate_of(longint x, longint prev, logic [63:0] dt);
         longint diff;
         logic [63:0] mag;
         logic [63:0] q;
         diff = x - prev;
         mag = (diff < 0) ? -diff : diff;
         q = (mag << FB) / dt;
         if (diff < 0)
            return (q > (64'd1 << (VW - 1))) ? -(64'sd1 <<< (VW - 1)) : -longint'(q);
         return (q > ((64'd1 << (VW - 1)) - 1)) ? (64'sd1 <<< (VW - 1)) - 1 : longint'(q);
      endfunction

      function void note_sample(sample_t s);
         logic [63:0] dt;
         logic [63:0] mag;
         logic [63:0] fc;
         longint raw[3];
         longint x;
         longint y;
         longint est;
         longint d;
         smooth_t o;
         bit first;
         raw[0] = longint'(s.x);
         raw[1] = longint'(s.y);
         raw[2] = longint'(s.z);
         dt = (s.dt == 0) ? 64'd1 : 64'(s.dt);
         first = first_pending || s.restart;
         for (int i = 0; i < 3; i++) begin
            x = raw[i];
            if (first) begin
               y = x;
               last_rate[i] = 0;
            end else begin
               d = rate_of(x, last_val[i], dt);
               est = mix(alpha_for(64'(delta_cutoff), dt), d, last_rate[i]);
               mag = (est < 0) ? -est : est;
               fc = 64'(min_cutoff) + ((64'(cutoff_slope) * mag) >> FB);
               if (fc > 64'hFFFF_FFFF) fc = 64'hFFFF_FFFF;
               last_rate[i] = est;
               y = mix(alpha_for(fc, dt), x, last_val[i]);
            end
            last_val[i] = y;
            raw[i] = y;
         end
         first_pending = 0;
         o.x = raw[0][VW-1:0];
         o.y = raw[1][VW-1:0];
         o.z = raw[2][VW-1:0];
         expected_smooth.push_back(o);
      endfunction

      function void check_output(smooth_t got);
         smooth_t want;
         if (expected_smooth.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            return;
         end
         want = expected_smooth.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            mismatches++;
            if (mismatches <= 10)
               $display("smooth mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        want.x, want.y, want.z, got.x, got.y, got.z);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [VW-1:0] req_sample_x;
   logic signed [VW-1:0] req_sample_y;
   logic signed [VW-1:0] req_sample_z;
   logic [DT_WIDTH-1:0] req_time_step;
   logic req_restart;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [VW-1:0] rsp_smooth_x;
   logic signed [VW-1:0] rsp_smooth_y;
   logic signed [VW-1:0] rsp_smooth_z;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0] csr_data;

   smoothing_tracker tracker = new();
   bit quiet;
   int accepted;
   longint track[3];

   one_euro_filter_3d_core dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Issue one sample transaction, holding it until the block takes it
   task automatic send_sample(sample_t s);
      bit stalled;
      while (!quiet && $urandom_range(99) < 10) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample_x <= s.x;
      req_sample_y <= s.y;
      req_sample_z <= s.z;
      req_time_step <= s.dt;
      req_restart <= s.restart;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      tracker.note_sample(s);
      accepted++;
   endtask

   // Write all three registers back to back, then release the port
   task automatic write_cutoffs(logic [CFG_WIDTH-1:0] mc, logic [CFG_WIDTH-1:0] cs,
                                logic [CFG_WIDTH-1:0] dc);
      logic [CFG_WIDTH-1:0] vals[3];
      logic [CSR_INDEX_WIDTH-1:0] idx[3];
      bit rdy;
      vals = '{mc, cs, dc};
      idx = '{REG_MIN_CUTOFF, REG_CUTOFF_SLOPE, REG_DELTA_CUTOFF};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         do begin
            @(negedge clock);
            rdy = csr_ready;
            @(posedge clock);
         end while (!rdy);
         tracker.set_reg(idx[i], vals[i]);
      end
      csr_valid <= 0;
   endtask

   task automatic drain_results();
      int n;
      n = 0;
      while (tracker.expected_smooth.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (300) @(posedge clock);
   endtask

   function automatic logic signed [VW-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[VW-1:0];
   endfunction

   // Mostly smooth tracking motion; some noise and restarts
   function automatic sample_t random_sample();
      sample_t s;
      int mode;
      mode = $urandom_range(99);
      if (mode < 20) begin
         s.x = $urandom;
         s.y = $urandom;
         s.z = $urandom;
         s.dt = DT_WIDTH'($urandom);
      end else begin
         for (int i = 0; i < 3; i++)
            track[i] = clamp32(track[i] + longint'($signed($urandom_range(2097152))) - 1048576);
         s.x = track[0][VW-1:0];
         s.y = track[1][VW-1:0];
         s.z = track[2][VW-1:0];
         s.dt = (mode < 30) ? DT_WIDTH'($urandom) : DT_WIDTH'($urandom_range(6554, 65));
      end
      s.restart = ($urandom_range(99) < 4);
      return s;
   endfunction

   // Result side: random stall, one long hold-off once the flow is going
   initial begin
      smooth_t got;
      bit held;
      held = 0;
      forever begin
         @(posedge clock);
         if (!held && accepted >= 300) begin
            held = 1;
            rsp_stall <= 1;
            for (int i = 0; i < 3000; i++) @(posedge clock);
         end
         rsp_stall <= (!quiet && $urandom_range(99) < 10);
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.x = rsp_smooth_x;
            got.y = rsp_smooth_y;
            got.z = rsp_smooth_z;
            tracker.check_output(got);
         end
      end
   end

   initial begin
      sample_t dir[$];
      logic [CFG_WIDTH-1:0] mc;
      logic [CFG_WIDTH-1:0] cs;
      logic [CFG_WIDTH-1:0] dc;
      quiet = 0;
      accepted = 0;
      track = '{0, 0, 0};
      reset <= 1;
      req_valid <= 0;
      req_sample_x <= 0;
      req_sample_y <= 0;
      req_sample_z <= 0;
      req_time_step <= 0;
      req_restart <= 0;
      rsp_stall <= 0;
      csr_valid <= 0;
      csr_index <= REG_MIN_CUTOFF;
      csr_data <= 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: first sample, extremes, rate saturation, odd time steps, restarts
      dir.push_back('{32'sd0, 32'sd0, 32'sd0, 17'd65536, 1'b0});
      dir.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65536, 17'd65536, 1'b0});
      dir.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd65536, 17'd1, 1'b0});
      dir.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 17'd1, 1'b0});
      dir.push_back('{32'sd100, 32'sd200, 32'sd300, 17'd0, 1'b0});
      dir.push_back('{32'sd70000, -32'sd70000, 32'sd5, 17'h1FFFF, 1'b0});
      dir.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 17'd655, 1'b1});
      dir.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd655, 1'b0});
      dir.push_back('{-32'sd1, 32'sd1, 32'sd0, 17'd65535, 1'b0});
      dir.push_back('{32'sd131072, 32'sd131072, 32'sd131072, 17'd1092, 1'b0});
      dir.push_back('{32'sd131072, 32'sd131072, 32'sd131072, 17'd1092, 1'b0});
      dir.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 17'h15555, 1'b0});
      dir.push_back('{32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0, 17'h0AAAA, 1'b0});
      dir.push_back('{32'sd42, 32'sd43, 32'sd44, 17'h1FFFF, 1'b1});
      dir.push_back('{32'sd1000000, -32'sd1000000, 32'sd0, 17'd0, 1'b0});
      dir.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 17'd0, 1'b0});
      foreach (dir[i]) send_sample(dir[i]);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) send_sample(random_sample());
      req_valid <= 0;
      drain_results();

      // Later phases: zero, full scale, random, then the reset settings again
      for (int ph = 1; ph < 5; ph++) begin
         case (ph)
            1: begin mc = 0; cs = 0; dc = 0; end
            2: begin mc = 24'hFFFFFF; cs = 24'hFFFFFF; dc = 24'hFFFFFF; end
            3: begin
               mc = CFG_WIDTH'($urandom);
               cs = CFG_WIDTH'($urandom);
               dc = CFG_WIDTH'($urandom);
            end
            default: begin mc = MIN_CUTOFF_RST; cs = CUTOFF_SLOPE_RST; dc = DELTA_CUTOFF_RST; end
         endcase
         write_cutoffs(mc, cs, dc);
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            quiet = (ph == 3 && k >= 50 && k < 200);
            send_sample(random_sample());
         end
         quiet = 0;
         req_valid <= 0;
         drain_results();
      end

      if (tracker.mismatches == 0 && tracker.expected_smooth.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
